### sv/pitch_lowering_resampler_assert.svh
// Assertion macros used by the resampler datapath (plr_dp).
`ifndef PITCH_LOWERING_RESAMPLER_ASSERT_SVH
`define PITCH_LOWERING_RESAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define PLR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
// Check that a condition implies another in the next cycle.
`define PLR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define PLR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PLR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### sv/plr_pkg.sv
// Shared types and constants of the pitch-lowering resampler.
package plr_pkg;

    localparam int DEF_MAX_CHANNELS     = 8;
    localparam int DEF_FRAME_INDEX_BITS = 24;

    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 3;
    localparam int CNT_W    = 4;
    localparam int STEP_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int ADDR_W   = 4;
    localparam int REG_IDX_W = 2;
    localparam int DATA_W   = 32;

    localparam logic [STEP_W-1:0]   STEP_MIN   = 16'd32768;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd32768;

    // Register reset values
    localparam logic [CNT_W-1:0]    RST_CHANNEL_COUNT = 4'd1;
    localparam logic [STEP_W-1:0]   RST_STEP          = 16'd53740;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT        = 16'd25559;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEP          = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT        = 2'd2;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [CNT_W-1:0]    cnt_eff;
        logic [STEP_W-1:0]   step_eff;
        logic [WEIGHT_W-1:0] weight_eff;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic            take;
        logic            interp;
        logic            smooth;
        logic            frame_done;
        logic            end_item;
        logic [CH_W-1:0] ch;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic main_now;
        logic tail_now;
        logic more_after;
        logic ch_last;
        logic out_free;
    } status_t;

endpackage

### sv/pitch_lowering_resampler.sv
// Top level of the pitch-lowering linear-interpolation resampler.
//
//  Channel  | Protocol     | Payload
//  ---------+--------------+-------------------------------------------------
//  s_axis   | stream in    | tdata = sample, tlast = final_req
//  m_axis   | stream out   | tdata = out_sample, tuser = out_channel,
//           |              | stream_done; tlast = run_last
//  cfg      | APB, 32 bit  | 0x0 channel_count, 0x4 step_q16, 0x8 smooth_weight
//
// An item is taken in S_IDLE, then S_CHECK looks for a due output frame;
// each result the item causes passes the interpolation multiplier in
// S_INTERP and then the smoothing multiplier in S_SMOOTH.
// A held output register (m_axis_tready low) stalls the smoothing step.
// Reset clears the stream counters; sample and output stores need no clearing.
module pitch_lowering_resampler #(
    parameter int MAX_CHANNELS     = plr_pkg::DEF_MAX_CHANNELS,
    parameter int FRAME_INDEX_BITS = plr_pkg::DEF_FRAME_INDEX_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample [15:0]
    input  logic [plr_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // out_sample [15:0]
    output logic [plr_pkg::SAMPLE_W-1:0]  m_axis_tdata,
    // out_channel [2:0], stream_done [3]
    output logic [plr_pkg::CH_W:0]        m_axis_tuser,
    output logic                          m_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plr_pkg::ADDR_W-1:0]    paddr,
    input  logic [plr_pkg::DATA_W-1:0]    pwdata,
    output logic [plr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import plr_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Configuration registers
    plr_regs #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    plr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Datapath
    plr_dp #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### sv/plr_regs.sv
// Configuration register file with APB-style access and clamped outputs.
module plr_regs #(
    parameter int MAX_CHANNELS = plr_pkg::DEF_MAX_CHANNELS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plr_pkg::ADDR_W-1:0]  paddr,
    input  logic [plr_pkg::DATA_W-1:0]  pwdata,
    output logic [plr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output plr_pkg::cfg_t               cfg
);
    import plr_pkg::*;

    logic [CNT_W-1:0]     chan_count_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= RST_CHANNEL_COUNT;
            step_reg       <= RST_STEP;
            weight_reg     <= RST_WEIGHT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CHANNEL_COUNT: chan_count_reg <= pwdata[CNT_W-1:0];
                REG_STEP:          step_reg       <= pwdata[STEP_W-1:0];
                REG_WEIGHT:        weight_reg     <= pwdata[WEIGHT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Read back raw values
    always_comb
    begin
        case (reg_idx)
            REG_CHANNEL_COUNT: prdata = DATA_W'(chan_count_reg);
            REG_STEP:          prdata = DATA_W'(step_reg);
            REG_WEIGHT:        prdata = DATA_W'(weight_reg);
            default:           prdata = '0;
        endcase
    end

    // Clamp to the legal ranges
    always_comb
    begin
        if (chan_count_reg == '0)
            cfg.cnt_eff = CNT_W'(1);
        else if (chan_count_reg > CNT_W'(MAX_CHANNELS))
            cfg.cnt_eff = CNT_W'(MAX_CHANNELS);
        else
            cfg.cnt_eff = chan_count_reg;
        cfg.step_eff   = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
        cfg.weight_eff = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    end

endmodule

### sv/plr_ctrl.sv
// Sequencer: takes an item, then walks output frames channel by channel.
module plr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  plr_pkg::status_t  status,
    output plr_pkg::cmd_t     cmd
);
    import plr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_INTERP,
        S_SMOOTH
    } state_t;

    state_t          state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.main_now || status.tail_now)
                begin
                    ch_next    = '0;
                    state_next = S_INTERP;
                end
                else
                begin
                    cmd.end_item = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                if (status.out_free)
                begin
                    cmd.smooth = 1'b1;
                    if (status.ch_last)
                    begin
                        cmd.frame_done = 1'b1;
                        ch_next        = '0;
                        if (status.more_after)
                            state_next = S_INTERP;
                        else
                        begin
                            cmd.end_item = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_INTERP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and channel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

### sv/plr_dp.sv
// Datapath: sample stores, stream counters, interpolate and smooth units, output register.
`include "pitch_lowering_resampler_assert.svh"
module plr_dp #(
    parameter int MAX_CHANNELS     = plr_pkg::DEF_MAX_CHANNELS,
    parameter int FRAME_INDEX_BITS = plr_pkg::DEF_FRAME_INDEX_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  plr_pkg::cfg_t                 cfg,
    input  plr_pkg::cmd_t                 cmd,
    output plr_pkg::status_t              status,
    input  logic [plr_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [plr_pkg::SAMPLE_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,
    output logic [plr_pkg::CH_W:0]        m_axis_tuser
);
    import plr_pkg::*;

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int FIB   = FRAME_INDEX_BITS;
    localparam int POS_W = FRAME_INDEX_BITS + 16;
    localparam logic [FRAME_INDEX_BITS-1:0] FRAME_MAX = '1;

    // Per-channel stores, undefined until written
    logic signed [SAMPLE_W-1:0] newest_reg   [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] older_reg    [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] last_out_reg [MAX_CHANNELS];

    // Stream control state
    logic [CH_W-1:0]  chan_idx_reg, chan_idx_next;
    logic [FIB-1:0]   frames_reg, frames_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             first_reg, first_next;
    logic             final_q_reg, final_q_next;
    logic             complete_q_reg, complete_q_next;
    logic [CNT_W-1:0] partial_reg, partial_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    logic signed [SAMPLE_W-1:0] interp_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [CH_W-1:0]            out_chan_reg;
    logic                       out_last_reg;
    logic                       out_done_reg;

    logic [IDX_W-1:0] take_idx, ch_idx;
    logic             take_complete;
    logic [CNT_W-1:0] take_next_cnt;
    logic [POS_W-1:0] pos_adv;
    logic [FIB-1:0]   pint_now, pint_adv, frames_m1;
    logic             main_now, tail_now, main_adv, tail_adv;

    // Interpolation signals
    logic signed [SAMPLE_W-1:0] older_sel, newest_sel, tail_val, left_v, right_v;
    logic [15:0]                frac;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [33:0]         iprod;
    logic signed [34:0]         isum, isum_adj;
    logic signed [SAMPLE_W-1:0] interp_v;

    // Smoothing signals
    logic signed [SAMPLE_W-1:0] prev_v;
    logic [WEIGHT_W-1:0]        weight;
    logic signed [SAMPLE_W:0]   sdiff;
    logic signed [33:0]         sprod;
    logic signed [34:0]         ssum, ssum_adj;
    logic signed [19:0]         squot;
    logic signed [SAMPLE_W-1:0] smooth_v;

    assign take_idx      = chan_idx_reg[IDX_W-1:0];
    assign ch_idx        = cmd.ch[IDX_W-1:0];
    assign take_next_cnt = {1'b0, chan_idx_reg} + CNT_W'(1);
    assign take_complete = (take_next_cnt >= cfg.cnt_eff);

    // Frame loop conditions at the current and the advanced position
    assign pos_adv   = pos_reg + POS_W'(cfg.step_eff);
    assign pint_now  = pos_reg[POS_W-1:16];
    assign pint_adv  = pos_adv[POS_W-1:16];
    assign frames_m1 = frames_reg - FIB'(1);
    assign main_now  = complete_q_reg && (frames_reg > FIB'(1)) && (pint_now < frames_m1);
    assign main_adv  = complete_q_reg && (frames_reg > FIB'(1)) && (pint_adv < frames_m1);
    assign tail_now  = final_q_reg && (frames_reg != '0) && (pint_now < frames_reg);
    assign tail_adv  = final_q_reg && (frames_reg != '0) && (pint_adv < frames_reg);

    assign status.main_now   = main_now;
    assign status.tail_now   = tail_now;
    assign status.more_after = main_adv || tail_adv;
    assign status.ch_last    = (({1'b0, cmd.ch} + CNT_W'(1)) == cfg.cnt_eff);
    assign status.out_free   = !out_valid_reg || m_axis_tready;

    // Interpolate between the two source frames; tail frames repeat the last one
    always_comb
    begin
        older_sel  = older_reg[ch_idx];
        newest_sel = newest_reg[ch_idx];
        tail_val   = ({1'b0, cmd.ch} < partial_reg) ? older_sel : newest_sel;
        left_v     = main_now ? older_sel : tail_val;
        right_v    = main_now ? newest_sel : tail_val;
        frac       = main_now ? pos_reg[15:0] : 16'd0;
        diff       = {right_v[SAMPLE_W-1], right_v} - {left_v[SAMPLE_W-1], left_v};
        iprod      = 34'(diff) * 34'($signed({1'b0, frac}));
        isum       = $signed({{3{left_v[SAMPLE_W-1]}}, left_v, 16'd0})
                     + $signed({iprod[33], iprod});
        // Truncate toward zero
        isum_adj   = isum + (isum[34] ? 35'sd65535 : 35'sd0);
        interp_v   = isum_adj[31:16];
    end

    // Smooth against the previous output: prev + (v - prev) * w / 32768
    always_comb
    begin
        prev_v   = first_reg ? '0 : last_out_reg[ch_idx];
        weight   = first_reg ? WEIGHT_ONE : cfg.weight_eff;
        sdiff    = {interp_reg[SAMPLE_W-1], interp_reg} - {prev_v[SAMPLE_W-1], prev_v};
        sprod    = 34'(sdiff) * 34'($signed({1'b0, weight}));
        ssum     = $signed({{4{prev_v[SAMPLE_W-1]}}, prev_v, 15'd0})
                   + $signed({sprod[33], sprod});
        ssum_adj = ssum + (ssum[34] ? 35'sd32767 : 35'sd0);
        squot    = ssum_adj[34:15];
        if (squot > 20'sd32767)
            smooth_v = 16'sh7fff;
        else if (squot < -20'sd32768)
            smooth_v = 16'sh8000;
        else
            smooth_v = squot[SAMPLE_W-1:0];
    end

    // Advance stream counters
    always_comb
    begin
        chan_idx_next   = chan_idx_reg;
        frames_next     = frames_reg;
        pos_next        = pos_reg;
        first_next      = first_reg;
        final_q_next    = final_q_reg;
        complete_q_next = complete_q_reg;
        partial_next    = partial_reg;
        if (cmd.take)
        begin
            chan_idx_next   = take_complete ? '0 : take_next_cnt[CH_W-1:0];
            final_q_next    = s_axis_tlast;
            complete_q_next = take_complete;
            partial_next    = take_complete ? '0 : take_next_cnt;
            if (take_complete && (frames_reg != FRAME_MAX))
                frames_next = frames_reg + FIB'(1);
        end
        if (cmd.frame_done)
        begin
            pos_next   = pos_adv;
            first_next = 1'b0;
        end
        // Drop stream state after the final item
        if (cmd.end_item && final_q_reg)
        begin
            chan_idx_next = '0;
            frames_next   = '0;
            pos_next      = '0;
            first_next    = 1'b1;
        end
        if (cmd.smooth)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_idx_reg   <= '0;
            frames_reg     <= '0;
            pos_reg        <= '0;
            first_reg      <= 1'b1;
            final_q_reg    <= 1'b0;
            complete_q_reg <= 1'b0;
            partial_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            chan_idx_reg   <= chan_idx_next;
            frames_reg     <= frames_next;
            pos_reg        <= pos_next;
            first_reg      <= first_next;
            final_q_reg    <= final_q_next;
            complete_q_reg <= complete_q_next;
            partial_reg    <= partial_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Write stores and payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            older_reg[take_idx]  <= newest_reg[take_idx];
            newest_reg[take_idx] <= $signed(s_axis_tdata);
        end
        if (cmd.interp)
            interp_reg <= interp_v;
        if (cmd.smooth)
        begin
            last_out_reg[ch_idx] <= smooth_v;
            out_sample_reg       <= smooth_v;
            out_chan_reg         <= cmd.ch;
            out_last_reg         <= status.ch_last && !status.more_after;
            out_done_reg         <= status.ch_last && !status.more_after && final_q_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_done_reg, out_chan_reg};

    `PLR_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_reg && !m_axis_tready, !cmd.smooth)
    `PLR_ASSERT_IMP(a_interp_has_frame, clk, rst_n, cmd.interp, main_now || tail_now)
    `PLR_ASSERT_IMP(a_done_is_last, clk, rst_n, out_valid_reg && out_done_reg, out_last_reg)
    `PLR_ASSERT_NXT(a_stream_cleared, clk, rst_n, cmd.end_item && final_q_reg,
                    frames_reg == '0 && pos_reg == '0 && first_reg)

endmodule

### bench/resampler_check.sv
// Checker for the pitch-lowering resampler: predicts each output item and compares it.
module resampler_check (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample [15:0]
    input  logic [plr_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // out_sample [15:0]
    input  logic [plr_pkg::SAMPLE_W-1:0]  m_axis_tdata,
    // out_channel [2:0], stream_done [3]
    input  logic [plr_pkg::CH_W:0]        m_axis_tuser,
    input  logic                          m_axis_tlast,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plr_pkg::ADDR_W-1:0]    paddr,
    input  logic [plr_pkg::DATA_W-1:0]    pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            outstanding
);
    import plr_pkg::*;

    typedef logic signed [SAMPLE_W-1:0] pcm_t;
    typedef pcm_t frame_t [DEF_MAX_CHANNELS];

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [CH_W-1:0]            chan;
        logic                       run_last;
        logic                       stream_done;
    } pcm_out_t;

    // Register copies, raw as written
    logic [CNT_W-1:0]    cfg_channels;
    logic [STEP_W-1:0]   cfg_step;
    logic [WEIGHT_W-1:0] cfg_weight;

    // Stream state of the resampler
    pcm_t                          src_new [DEF_MAX_CHANNELS];
    pcm_t                          src_old [DEF_MAX_CHANNELS];
    pcm_t                          prev_out [DEF_MAX_CHANNELS];
    logic [CH_W-1:0]               chan_pos;
    logic [DEF_FRAME_INDEX_BITS-1:0] frames_seen;
    logic [39:0]                   read_pos;
    logic                          first_pending;

    pcm_out_t expected_q [$];
    pcm_out_t got;
    pcm_out_t want;
    int       produced;
    int       errors;

    function automatic pcm_t clip16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return pcm_t'(v);
    endfunction

    // Emit one output frame: interpolate, smooth with the previous output, saturate
    function void emit_frame(input frame_t lhs, input frame_t rhs,
                             input logic [STEP_W-1:0] frac, input int cnt);
        longint   w;
        longint   l;
        longint   r;
        longint   v;
        pcm_out_t res;
        w = (cfg_weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(cfg_weight);
        for (int ch = 0; ch < cnt; ch++)
        begin
            l = longint'(lhs[ch]);
            r = longint'(rhs[ch]);
            v = (l * 65536 + (r - l) * longint'(frac)) / 65536;
            if (!first_pending)
                v = (v * w + longint'(prev_out[ch]) * (32768 - w)) / 32768;
            res.value       = clip16(v);
            res.chan        = ch[CH_W-1:0];
            res.run_last    = 1'b0;
            res.stream_done = 1'b0;
            prev_out[ch]    = res.value;
            expected_q.insert(expected_q.size(), res);
            produced++;
        end
        first_pending = 1'b0;
    endfunction

    // Work out every output item caused by one input item
    function void predict_item(input pcm_t smp, input logic fin);
        int              cnt;
        int              partial;
        logic [STEP_W-1:0] step;
        logic [CH_W-1:0] c;
        logic            complete;
        logic [39:0]     limit;
        frame_t          tail;
        cnt = (cfg_channels == 0) ? 1 :
              ((cfg_channels > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : int'(cfg_channels));
        step = (cfg_step < STEP_MIN) ? STEP_MIN : cfg_step;
        c = chan_pos;
        complete = (int'(c) + 1 >= cnt);
        produced = 0;

        src_old[c] = src_new[c];
        src_new[c] = smp;

        if (complete)
        begin
            chan_pos = '0;
            if (frames_seen != '1)
                frames_seen++;
            if (frames_seen >= 2)
            begin
                limit = (40'(frames_seen) - 40'd1) << 16;
                while (read_pos < limit)
                begin
                    emit_frame(src_old, src_new, read_pos[15:0], cnt);
                    read_pos += 40'(step);
                end
            end
        end
        else
            chan_pos = c + 1'b1;

        // Flush tail positions from the last complete frame, then restart the stream
        if (fin)
        begin
            partial = complete ? 0 : int'(c) + 1;
            for (int ch = 0; ch < DEF_MAX_CHANNELS; ch++)
                tail[ch] = (ch < partial) ? src_old[ch] : src_new[ch];
            if (frames_seen >= 1)
            begin
                limit = 40'(frames_seen) << 16;
                while (read_pos < limit)
                begin
                    emit_frame(tail, tail, '0, cnt);
                    read_pos += 40'(step);
                end
            end
            chan_pos      = '0;
            frames_seen   = '0;
            read_pos      = '0;
            first_pending = 1'b1;
        end

        // Mark the last output of this item
        if (produced > 0)
        begin
            expected_q[expected_q.size() - 1].run_last    = 1'b1;
            expected_q[expected_q.size() - 1].stream_done = fin;
        end
    endfunction

    function void note_failure(input string what);
        if (errors < 10)
            $display("%s: expected value %0d ch %0d last %0b done %0b, got value %0d ch %0d last %0b done %0b",
                     what, $signed(want.value), want.chan, want.run_last, want.stream_done,
                     $signed(got.value), got.chan, got.run_last, got.stream_done);
        errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_channels  = RST_CHANNEL_COUNT;
            cfg_step      = RST_STEP;
            cfg_weight    = RST_WEIGHT;
            for (int ch = 0; ch < DEF_MAX_CHANNELS; ch++)
            begin
                src_new[ch]  = '0;
                src_old[ch]  = '0;
                prev_out[ch] = '0;
            end
            chan_pos      = '0;
            frames_seen   = '0;
            read_pos      = '0;
            first_pending = 1'b1;
            expected_q.delete();
            errors        = 0;
            fail_count   <= 0;
            outstanding  <= 0;
        end
        else
        begin
            // Compare a leaving item with the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value       = m_axis_tdata;
                got.chan        = m_axis_tuser[CH_W-1:0];
                got.stream_done = m_axis_tuser[CH_W];
                got.run_last    = m_axis_tlast;
                if (expected_q.size() == 0)
                begin
                    want = '0;
                    note_failure("unexpected item");
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.value !== want.value || got.chan !== want.chan ||
                        got.run_last !== want.run_last || got.stream_done !== want.stream_done)
                        note_failure("item mismatch");
                end
            end

            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    {REG_CHANNEL_COUNT, 2'b00}: cfg_channels = pwdata[CNT_W-1:0];
                    {REG_STEP, 2'b00}:          cfg_step     = pwdata[STEP_W-1:0];
                    {REG_WEIGHT, 2'b00}:        cfg_weight   = pwdata[WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tdata, s_axis_tlast);

            fail_count  <= errors;
            outstanding <= expected_q.size();
        end
    end

endmodule

### bench/tb_pitch_lowering_resampler.sv
// Testbench top for the pitch-lowering resampler: stimulus, flow control and verdict.
module tb_pitch_lowering_resampler;
    import plr_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic [SAMPLE_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] m_axis_tdata;
    logic [CH_W:0]       m_axis_tuser;
    logic                m_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int   fail_count;
    int   outstanding;
    int   items_sent = 0;
    int   calm_mark = 1 << 30;
    int   eff_chans = 1;
    int   directed_end;
    int   stall_left = 0;
    logic calm = 1'b0;
    logic long_hold = 1'b0;

    pitch_lowering_resampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    resampler_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the output side in random bursts; hold it off entirely on request
    always @(negedge clk)
    begin
        if (long_hold)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Hold off the receiver for a long stretch while samples keep coming
    initial
    begin
        wait (items_sent >= 130);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (500) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        #8000000;
        $display("[pitch_lowering_resampler] ERROR");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] pick_pcm();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 7)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one sample, with an occasional gap first; entered and left at a falling edge
    task automatic push_sample(input logic [SAMPLE_W-1:0] pcm, input logic fin);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = pcm;
        s_axis_tlast  = fin;
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (items_sent >= calm_mark)
            calm = 1'b1;
        @(negedge clk);
    endtask

    // Drain every expected item, then give the block time to finish a silent item
    task automatic settle();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [CNT_W-1:0] chans, input logic [STEP_W-1:0] step,
                              input logic [WEIGHT_W-1:0] weight);
        settle();
        write_reg(REG_CHANNEL_COUNT, DATA_W'(chans));
        write_reg(REG_STEP, DATA_W'(step));
        write_reg(REG_WEIGHT, DATA_W'(weight));
        eff_chans = (chans == 0) ? 1 :
                    ((chans > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : int'(chans));
    endtask

    // Send whole frames plus a partial frame; the last sample closes the stream
    task automatic play_stream(input int frames, input int partial);
        int total;
        total = frames * eff_chans + partial;
        for (int i = 0; i < total; i++)
            push_sample(pick_pcm(), i == total - 1);
    endtask

    initial
    begin
        logic [CNT_W-1:0]    chans;
        logic [STEP_W-1:0]   step;
        logic [WEIGHT_W-1:0] weight;
        int                  frames;
        int                  partial;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings, full-scale swings
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);

        // Two channels, slowest step, full weight, partial final frame dropped
        set_config(4'd2, 16'd32768, 16'd32768);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h1234, 1'b1);

        // Out-of-range registers: zero channels, step below minimum, weight above one
        set_config(4'd0, 16'd0, 16'hFFFF);
        push_sample(16'h8000, 1'b1);

        // Channel count above maximum, final before any complete frame
        set_config(4'hF, 16'hFFFF, 16'd0);
        push_sample(16'h5A5A, 1'b0);
        push_sample(16'hA5A5, 1'b0);
        push_sample(16'h7FFF, 1'b1);

        // Lower the channel count in the middle of a frame
        set_config(4'd3, RST_STEP, RST_WEIGHT);
        for (int i = 0; i < 7; i++)
            push_sample(pick_pcm(), 1'b0);
        set_config(4'd1, 16'd40000, 16'd12345);
        push_sample(16'h4000, 1'b0);
        push_sample(16'hC000, 1'b1);

        // Random streams, mostly well formed, with random settings between them
        directed_end = items_sent;
        calm_mark    = directed_end + 340;
        while (items_sent < directed_end + 420)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                chans = ($urandom_range(0, 9) == 0) ?
                        (($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15))) :
                        4'($urandom_range(1, 8));
                case ($urandom_range(0, 7))
                    0:       step = 16'd32768;
                    1:       step = 16'hFFFF;
                    2:       step = 16'($urandom_range(0, 32767));
                    default: step = 16'($urandom_range(32768, 65535));
                endcase
                case ($urandom_range(0, 7))
                    0:       weight = 16'd0;
                    1:       weight = 16'd32768;
                    2:       weight = 16'($urandom_range(32769, 65535));
                    default: weight = 16'($urandom_range(0, 32768));
                endcase
                set_config(chans, step, weight);
            end
            frames  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
            partial = (eff_chans > 1 && $urandom_range(0, 3) == 0) ?
                      $urandom_range(1, eff_chans - 1) : 0;
            if (frames == 0 && partial == 0)
                frames = 1;
            play_stream(frames, partial);
        end

        settle();
        if (fail_count == 0)
            $display("[pitch_lowering_resampler] OK");
        else
            $display("[pitch_lowering_resampler] ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/plr_pkg.sv
sv/plr_regs.sv
sv/plr_ctrl.sv
sv/plr_dp.sv
sv/pitch_lowering_resampler.sv
bench/resampler_check.sv
bench/tb_pitch_lowering_resampler.sv
